FILE: hw/rtl/bmf_pkg.sv
// Shared types and constants of the 3x3 box mean filter.
`timescale 1ns / 1ps

package bmf_pkg;

	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 12;
	localparam int CFG_DATA_W     = 12;
	localparam int CFG_INDEX_W    = 1;

	localparam logic [FRAME_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 11'd640;
	localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

	// Item kinds on the input channel
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Which window neighbors of the output pixel lie inside the frame
	typedef struct packed {
		logic left;
		logic right;
		logic top;
		logic bottom;
	} border_mask_t;

	typedef struct packed {
		logic         emit;
		logic         last;
		border_mask_t mask;
	} emit_ctrl_t;

endpackage

FILE: hw/rtl/bmf_line_store.sv
// Two-line pixel store: one memory row per column holding {older, newer} pixels.
`timescale 1ns / 1ps

module bmf_line_store #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] fwd_q;
	logic              fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// A read issued on the same edge as a write to that row sees the new row
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_hit_q ? fwd_q : rd_q;

endmodule

FILE: hw/rtl/bmf_mean.sv
// Masked 3x3 window sum and truncating division by the in-frame pixel count.
`timescale 1ns / 1ps

module bmf_mean #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  bmf_pkg::emit_ctrl_t    ctrl,
	input  logic [PIXEL_BITS-1:0]  window [9],
	output logic                   emit,
	output logic                   last,
	output logic [PIXEL_BITS-1:0]  quotient
);

	localparam int SUM_W  = PIXEL_BITS + 4;
	localparam int K      = SUM_W + 4;
	localparam int PROD_W = SUM_W + K;
	localparam longint unsigned M3 = (64'd1 << K) / 3 + 1;
	localparam longint unsigned M6 = (64'd1 << K) / 6 + 1;
	localparam longint unsigned M9 = (64'd1 << K) / 9 + 1;

	localparam logic [3:0] CNT_ONE   = 4'd1;
	localparam logic [3:0] CNT_TWO   = 4'd2;
	localparam logic [3:0] CNT_THREE = 4'd3;
	localparam logic [3:0] CNT_FOUR  = 4'd4;
	localparam logic [3:0] CNT_SIX   = 4'd6;
	localparam logic [3:0] CNT_NINE  = 4'd9;

	logic [SUM_W-1:0]  sum;
	logic [3:0]        cnt;
	logic [1:0]        cols;
	logic [1:0]        lines;
	logic [2:0]        col_ok;
	logic [2:0]        line_ok;
	logic [SUM_W-1:0]  sum_s3;
	logic [3:0]        cnt_s3;
	logic              emit_s3;
	logic              last_s3;
	logic [PROD_W-1:0] prod3;
	logic [PROD_W-1:0] prod6;
	logic [PROD_W-1:0] prod9;

	assign col_ok  = {ctrl.mask.right, 1'b1, ctrl.mask.left};
	assign line_ok = {ctrl.mask.bottom, 1'b1, ctrl.mask.top};
	assign cols    = 2'd1 + 2'(ctrl.mask.left) + 2'(ctrl.mask.right);
	assign lines   = 2'd1 + 2'(ctrl.mask.top) + 2'(ctrl.mask.bottom);
	assign cnt     = 4'(cols) * 4'(lines);

	always_comb begin
		sum = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (col_ok[c] && line_ok[r]) begin
					sum = sum + SUM_W'(window[c*3+r]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sum;
			cnt_s3  <= cnt;
			last_s3 <= ctrl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s3 <= 1'b0;
		end else if (en) begin
			emit_s3 <= ctrl.emit;
		end
	end

	// Reciprocal multiplies; K is wide enough that the floor is exact over the sum range
	assign prod3 = PROD_W'(sum_s3) * PROD_W'(M3);
	assign prod6 = PROD_W'(sum_s3) * PROD_W'(M6);
	assign prod9 = PROD_W'(sum_s3) * PROD_W'(M9);

	always_comb begin
		unique case (cnt_s3)
			CNT_ONE:   quotient = sum_s3[PIXEL_BITS-1:0];
			CNT_TWO:   quotient = sum_s3[PIXEL_BITS:1];
			CNT_THREE: quotient = prod3[K +: PIXEL_BITS];
			CNT_FOUR:  quotient = sum_s3[PIXEL_BITS+1:2];
			CNT_SIX:   quotient = prod6[K +: PIXEL_BITS];
			CNT_NINE:  quotient = prod9[K +: PIXEL_BITS];
			default:   quotient = '0;
		endcase
	end

	assign emit = emit_s3;
	assign last = last_s3;

	a_cnt_legal: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s3 |-> (cnt_s3 == CNT_ONE || cnt_s3 == CNT_TWO || cnt_s3 == CNT_THREE ||
			cnt_s3 == CNT_FOUR || cnt_s3 == CNT_SIX || cnt_s3 == CNT_NINE))
		else $error("mean stage holds an impossible pixel count");

	a_emit_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ctrl.emit && ctrl.last) |=> (emit_s3 && last_s3))
		else $error("frame end lost between window and sum stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && emit_s3) |=> emit_s3)
		else $error("pending sum dropped while stalled");

endmodule

FILE: hw/rtl/box_mean_filter_3x3_top.sv
// Top level of the streaming 3x3 box mean filter.
// Throughput: one item per cycle while result_stall does not hold the output; the store read,
//   window, adder and divider each sit in their own stage, so every stage takes a new item on
//   every clock unless the output stalls. Pipeline: a result passes the stage 1, window, sum
//   and output registers; results trail the pixel stream by frame_width + 1 items.
// Reset: counters, pipeline valids and registers (640 x 480) clear at once; the line store
//   is not cleared, since unwritten rows only feed masked window slots.
`timescale 1ns / 1ps

module box_mean_filter_3x3_top #(
	parameter int MAX_LINE_PIXELS = 1024,
	parameter int MAX_FRAME_LINES = 4095,
	parameter int PIXEL_BITS      = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            func,
	input  logic [PIXEL_BITS-1:0]           pixel,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [PIXEL_BITS-1:0]           mean_value,
	output logic                            frame_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bmf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int COL_W  = $clog2(MAX_LINE_PIXELS);
	localparam int WID_W  = $clog2(MAX_LINE_PIXELS + 1);
	localparam int PEND_W = $clog2(MAX_LINE_PIXELS + 2);
	localparam int LINE_W = $clog2(MAX_FRAME_LINES + 1);

	// Configuration
	logic [bmf_pkg::FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [bmf_pkg::FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [WID_W-1:0]                   eff_w;
	logic [LINE_W-1:0]                  eff_h;

	// Position state
	logic [COL_W-1:0]  in_col_q, in_col_d;
	logic [LINE_W-1:0] in_line_q, in_line_d;
	logic [COL_W-1:0]  out_col_q, out_col_d;
	logic [LINE_W-1:0] out_line_q, out_line_d;
	logic [PEND_W-1:0] pend_q, pend_d;

	// Step decode
	logic              adv;
	logic              acc;
	logic [COL_W-1:0]  x;
	logic [COL_W-1:0]  oc;
	logic [WID_W-1:0]  x_inc;
	logic              x_wrap;
	logic [COL_W-1:0]  x_next;
	logic [WID_W-1:0]  oc_inc;
	logic [LINE_W:0]   ol_inc;
	logic              line_full;
	logic              pend_full;
	logic              do_shift;
	logic              do_wr;
	logic              do_emit;
	logic [PIXEL_BITS-1:0]   bottom_px;
	bmf_pkg::border_mask_t   mask;
	logic                    emit_last;

	// Stage 1: line store read in flight
	logic                  shift_s1;
	logic                  wr_s1;
	logic                  emit_s1;
	logic                  last_s1;
	bmf_pkg::border_mask_t mask_s1;
	logic [COL_W-1:0]      addr_s1;
	logic [PIXEL_BITS-1:0] bottom_s1;
	logic [2*PIXEL_BITS-1:0] store_rd;
	logic [PIXEL_BITS-1:0]   older_px;
	logic [PIXEL_BITS-1:0]   newer_px;

	// Stage 2: window
	logic [PIXEL_BITS-1:0] window_q [9];
	bmf_pkg::emit_ctrl_t   ctrl_s2;
	logic                  emit_s2;
	logic                  last_s2;
	bmf_pkg::border_mask_t mask_s2;

	// Stage 3 / output
	logic                  emit_s3;
	logic                  last_s3;
	logic [PIXEL_BITS-1:0] quot_s3;
	logic                  result_valid_q;
	logic [PIXEL_BITS-1:0] mean_q;
	logic                  frame_last_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= bmf_pkg::RESET_FRAME_WIDTH;
			frame_height_q <= bmf_pkg::RESET_FRAME_HEIGHT;
		end else if (cfg_valid) begin
			unique case (bmf_pkg::cfg_reg_t'(cfg_index))
				bmf_pkg::CFG_FRAME_WIDTH:
					frame_width_q <= cfg_data[bmf_pkg::FRAME_WIDTH_W-1:0];
				bmf_pkg::CFG_FRAME_HEIGHT:
					frame_height_q <= cfg_data[bmf_pkg::FRAME_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = WID_W'(1);
		end else if (32'(frame_width_q) > 32'(MAX_LINE_PIXELS)) begin
			eff_w = WID_W'(MAX_LINE_PIXELS);
		end else begin
			eff_w = WID_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			eff_h = LINE_W'(1);
		end else if (32'(frame_height_q) > 32'(MAX_FRAME_LINES)) begin
			eff_h = LINE_W'(MAX_FRAME_LINES);
		end else begin
			eff_h = LINE_W'(frame_height_q);
		end
	end

	// ---------------- handshake ----------------
	assign adv        = !(result_valid_q && result_stall);
	assign item_stall = !adv;
	assign acc        = item_valid && adv;

	// ---------------- step decode ----------------
	always_comb begin
		x         = (WID_W'(in_col_q) >= eff_w) ? '0 : in_col_q;
		oc        = (WID_W'(out_col_q) >= eff_w) ? '0 : out_col_q;
		x_inc     = WID_W'(x) + WID_W'(1);
		x_wrap    = x_inc >= eff_w;
		x_next    = x_wrap ? '0 : x_inc[COL_W-1:0];
		oc_inc    = WID_W'(oc) + WID_W'(1);
		ol_inc    = (LINE_W+1)'(out_line_q) + (LINE_W+1)'(1);
		line_full = in_line_q >= eff_h;
		pend_full = pend_q >= (PEND_W'(eff_w) + PEND_W'(1));

		mask.left   = oc != '0;
		mask.right  = oc_inc < eff_w;
		mask.top    = out_line_q != '0;
		mask.bottom = ol_inc < (LINE_W+1)'(eff_h);
		emit_last   = !mask.right && !mask.bottom;

		in_col_d   = x;
		in_line_d  = in_line_q;
		out_col_d  = oc;
		out_line_d = out_line_q;
		pend_d     = pend_q;
		do_shift   = 1'b0;
		do_wr      = 1'b0;
		do_emit    = 1'b0;
		bottom_px  = pixel;

		if (func == bmf_pkg::FUNC_PIXEL) begin
			// pixels that arrive during a flush are dropped
			if (!line_full) begin
				do_shift = 1'b1;
				do_wr    = 1'b1;
				in_col_d = x_next;
				if (x_wrap) begin
					in_line_d = in_line_q + LINE_W'(1);
				end
				if (pend_full) begin
					do_emit = 1'b1;
				end else begin
					pend_d = pend_q + PEND_W'(1);
				end
			end
		end else begin
			bottom_px = '0;
			// a drain before the frame's last pixel does nothing
			if (line_full) begin
				if (pend_q == '0) begin
					in_col_d  = '0;
					in_line_d = '0;
				end else begin
					do_shift = 1'b1;
					in_col_d = x_next;
					if (pend_full) begin
						do_emit = 1'b1;
						if (emit_last) begin
							pend_d    = '0;
							in_col_d  = '0;
							in_line_d = '0;
						end
					end else begin
						pend_d = pend_q + PEND_W'(1);
					end
				end
			end
		end

		if (do_emit) begin
			out_col_d = mask.right ? oc_inc[COL_W-1:0] : '0;
			if (!mask.right) begin
				out_line_d = (ol_inc >= (LINE_W+1)'(eff_h)) ? '0 : ol_inc[LINE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_line_q  <= '0;
			out_col_q  <= '0;
			out_line_q <= '0;
			pend_q     <= '0;
		end else if (acc) begin
			in_col_q   <= in_col_d;
			in_line_q  <= in_line_d;
			out_col_q  <= out_col_d;
			out_line_q <= out_line_d;
			pend_q     <= pend_d;
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s1 <= 1'b0;
			wr_s1    <= 1'b0;
			emit_s1  <= 1'b0;
		end else if (adv) begin
			shift_s1 <= acc && do_shift;
			wr_s1    <= acc && do_wr;
			emit_s1  <= acc && do_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			last_s1   <= emit_last;
			mask_s1   <= mask;
			addr_s1   <= x;
			bottom_s1 <= bottom_px;
		end
	end

	bmf_line_store #(
		.DEPTH  (MAX_LINE_PIXELS),
		.ADDR_W (COL_W),
		.DATA_W (2*PIXEL_BITS)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc && do_shift),
		.rd_addr (x),
		.wr_en   (adv && wr_s1),
		.wr_addr (addr_s1),
		.wr_data ({newer_px, bottom_s1}),
		.rd_data (store_rd)
	);

	assign older_px = store_rd[2*PIXEL_BITS-1:PIXEL_BITS];
	assign newer_px = store_rd[PIXEL_BITS-1:0];

	// ---------------- stage 2: window ----------------
	always_ff @(posedge clk) begin
		if (adv && shift_s1) begin
			for (int i = 0; i < 6; i++) begin
				window_q[i] <= window_q[i+3];
			end
			window_q[6] <= older_px;
			window_q[7] <= newer_px;
			window_q[8] <= bottom_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			mask_s2 <= mask_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else if (adv) begin
			emit_s2 <= emit_s1;
		end
	end

	assign ctrl_s2 = '{emit: emit_s2, last: last_s2, mask: mask_s2};

	// ---------------- stage 3: sum and divide ----------------
	bmf_mean #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ctrl     (ctrl_s2),
		.window   (window_q),
		.emit     (emit_s3),
		.last     (last_s3),
		.quotient (quot_s3)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mean_q       <= quot_s3;
			frame_last_q <= last_s3;
		end
	end

	assign result_valid = result_valid_q;
	assign mean_value   = mean_q;
	assign frame_last   = frame_last_q;

	// ---------------- assertions ----------------
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(MAX_LINE_PIXELS + 1))
		else $error("owed result count beyond line plus one");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(emit_s3))
		else $error("result appeared without a computed mean");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && func == bmf_pkg::FUNC_DRAIN && do_emit && emit_last)
			|=> (pend_q == '0 && in_line_q == '0 && in_col_q == '0))
		else $error("frame end did not rearm the input position");

endmodule

FILE: sim/box_mean_filter_3x3_top_test.sv
// Self-checking testbench for the streaming 3x3 box mean filter.
`timescale 1ns / 1ps

module box_mean_filter_3x3_top_test;

	localparam int LINE_DEPTH = 1024;
	localparam int LINES_MAX  = 4095;

	typedef struct packed {
		logic [7:0] mean;
		logic       last;
	} mean_result_t;

	// Filter state mirror plus the queue of means still owed by the block.
	class mean_scoreboard;
		int unsigned width_reg, height_reg;
		bit [7:0] older_row [LINE_DEPTH];
		bit [7:0] newer_row [LINE_DEPTH];
		bit [7:0] win [9]; // column * 3 + line, column 0 leftmost
		int unsigned in_col, in_line, out_col, out_line, owed;
		mean_result_t owed_means [$];
		int mismatches, results_seen, frame_ends;

		function void reset_state();
			width_reg = 32'(bmf_pkg::RESET_FRAME_WIDTH);
			height_reg = 32'(bmf_pkg::RESET_FRAME_HEIGHT);
			foreach (older_row[i]) older_row[i] = '0;
			foreach (newer_row[i]) newer_row[i] = '0;
			foreach (win[i]) win[i] = '0;
			in_col = 0;
			in_line = 0;
			out_col = 0;
			out_line = 0;
			owed = 0;
		endfunction

		function void set_reg(bmf_pkg::cfg_reg_t idx, int unsigned val);
			if (idx == bmf_pkg::CFG_FRAME_WIDTH)
				width_reg = val & 32'h7FF;
			else
				height_reg = val & 32'hFFF;
		endfunction

		function int unsigned eff_width();
			if (width_reg == 0)
				return 1;
			return (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg == 0)
				return 1;
			return (height_reg > LINES_MAX) ? LINES_MAX : height_reg;
		endfunction

		function bit is_ignored(logic f);
			if (f == bmf_pkg::FUNC_PIXEL)
				return in_line >= eff_height();
			return in_line < eff_height();
		endfunction

		function bit is_clean();
			return in_col == 0 && in_line == 0 && owed == 0;
		endfunction

		function void shift_column(bit [7:0] top, bit [7:0] mid, bit [7:0] bot);
			for (int i = 0; i < 6; i++)
				win[i] = win[i + 3];
			win[6] = top;
			win[7] = mid;
			win[8] = bot;
		endfunction

		// Mean over the in-frame part of the window, then advance the output position.
		function void emit_mean(int unsigned w, int unsigned h, output mean_result_t r);
			bit col_ok [3];
			bit line_ok [3];
			int unsigned acc, cnt;
			col_ok[0] = out_col > 0;
			col_ok[1] = 1'b1;
			col_ok[2] = out_col + 1 < w;
			line_ok[0] = out_line > 0;
			line_ok[1] = 1'b1;
			line_ok[2] = out_line + 1 < h;
			acc = 0;
			cnt = 0;
			for (int c = 0; c < 3; c++)
				for (int l = 0; l < 3; l++)
					if (col_ok[c] && line_ok[l]) begin
						acc += 32'(win[c * 3 + l]);
						cnt++;
					end
			r.mean = 8'(acc / cnt);
			r.last = (out_line + 1 >= h) && (out_col + 1 >= w);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_line++;
				if (out_line >= h)
					out_line = 0;
			end
		endfunction

		function bit advance_filter(logic f, logic [7:0] p, output mean_result_t r);
			int unsigned w, h, x;
			w = eff_width();
			h = eff_height();
			r = '0;
			if (in_col >= w)
				in_col = 0;
			if (out_col >= w)
				out_col = 0;
			x = in_col;
			if (f == bmf_pkg::FUNC_PIXEL) begin
				if (in_line >= h)
					return 0;
				shift_column(older_row[x], newer_row[x], p);
				older_row[x] = newer_row[x];
				newer_row[x] = p;
				in_col++;
				if (in_col >= w) begin
					in_col = 0;
					in_line++;
				end
				if (owed >= w + 1) begin
					emit_mean(w, h, r);
					return 1;
				end
				owed++;
				return 0;
			end
			if (in_line < h)
				return 0;
			if (owed == 0) begin
				in_col = 0;
				in_line = 0;
				return 0;
			end
			// drain: zeros enter the bottom line, which is masked on the last line
			shift_column(older_row[x], newer_row[x], 8'd0);
			in_col++;
			if (in_col >= w)
				in_col = 0;
			if (owed >= w + 1) begin
				emit_mean(w, h, r);
				if (r.last) begin
					owed = 0;
					in_col = 0;
					in_line = 0;
				end
				return 1;
			end
			owed++;
			return 0;
		endfunction

		function void note_item(logic f, logic [7:0] p);
			mean_result_t r;
			if (advance_filter(f, p, r))
				owed_means.push_back(r);
		endfunction

		function void check_result(logic [7:0] m, logic l);
			mean_result_t e;
			results_seen++;
			if (owed_means.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: mean %0d last %0b", m, l);
				return;
			end
			e = owed_means.pop_front();
			if (e.mean !== m || e.last !== l) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at result %0d: expected mean %0d last %0b, %s %0d last %0b",
						results_seen, e.mean, e.last, "got mean", m, l);
			end else if (l) begin
				frame_ends++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            item_valid;
	logic                            item_stall;
	logic                            func;
	logic [7:0]                      pixel;
	logic                            result_valid;
	logic                            result_stall;
	logic [7:0]                      mean_value;
	logic                            frame_last;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [bmf_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data;

	mean_scoreboard sb;
	mean_scoreboard plan; // sender-side copy, tracks where the stream stands
	int unsigned fed_items;
	int unsigned burst_left;
	int unsigned phases;
	bit hold_done;

	box_mean_filter_3x3_top dut (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("timeout: %0d means still owed", sb.owed_means.size());
		$display("box_mean_filter_3x3_top_test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result(mean_value, frame_last);
			if (item_valid && !item_stall)
				sb.note_item(func, pixel);
			if (cfg_valid && cfg_ready)
				sb.set_reg(bmf_pkg::cfg_reg_t'(cfg_index), 32'(cfg_data));
		end
	end

	// Receiver: the stall pattern is redrawn at random intervals, plus one long hold-off.
	initial begin
		int unsigned mode, tick;
		result_stall = 1'b0;
		hold_done = 1'b0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(16, 96)) begin
				@(negedge clk);
				tick++;
				if (!hold_done && sb.results_seen >= 150) begin
					hold_done = 1'b1;
					result_stall = 1'b1;
					repeat (400) @(negedge clk);
				end
				case (mode)
					0: result_stall = 1'b0;
					1: result_stall = ($urandom_range(0, 2) == 0);
					2: result_stall = (tick % 4 == 3);
					default: result_stall = ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic offer(input logic f, input logic [7:0] p);
		mean_result_t unused;
		int unsigned gap;
		if (!plan.is_ignored(f))
			fed_items++;
		void'(plan.advance_filter(f, p, unused));
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 48);
			if (gap > 0) begin
				@(negedge clk);
				item_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		item_valid = 1'b1;
		func = f;
		pixel = p;
		do @(posedge clk); while (item_stall);
		burst_left--;
	endtask

	task automatic write_reg(input bmf_pkg::cfg_reg_t idx, input int unsigned val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = bmf_pkg::CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		plan.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Let every owed mean arrive, then wait out the items still in the pipe.
	task automatic wait_drained();
		@(negedge clk);
		item_valid = 1'b0;
		burst_left = 0;
		while (sb.owed_means.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		wait_drained();
		write_reg(bmf_pkg::CFG_FRAME_WIDTH, w);
		write_reg(bmf_pkg::CFG_FRAME_HEIGHT, h);
		phases++;
	endtask

	// Complete any open frame and flush it so the next settings start clean.
	task automatic close_stream();
		while (!plan.is_clean()) begin
			if (plan.in_line < plan.eff_height())
				offer(bmf_pkg::FUNC_PIXEL, 8'($urandom));
			else
				offer(bmf_pkg::FUNC_DRAIN, 8'($urandom));
		end
	endtask

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// One frame with random content; now and then stray drains, stray pixels in
	// the flush, or a flush cut short so the next frame starts against it.
	task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
		int unsigned flush;
		for (int unsigned i = 0; i < w * h; i++) begin
			if (noisy && $urandom_range(0, 29) == 0)
				offer(bmf_pkg::FUNC_DRAIN, 8'($urandom));
			offer(bmf_pkg::FUNC_PIXEL, rand_pixel());
		end
		flush = w + 1;
		if (noisy && $urandom_range(0, 7) == 0)
			flush = $urandom_range(0, w);
		for (int unsigned i = 0; i < flush; i++) begin
			if (noisy && $urandom_range(0, 11) == 0)
				offer(bmf_pkg::FUNC_PIXEL, 8'($urandom));
			offer(bmf_pkg::FUNC_DRAIN, 8'($urandom));
		end
		if (noisy && $urandom_range(0, 5) == 0)
			offer(bmf_pkg::FUNC_DRAIN, 8'($urandom));
	endtask

	initial begin
		int unsigned w, h, start_count;
		item_valid = 1'b0;
		func = bmf_pkg::FUNC_PIXEL;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = bmf_pkg::CFG_FRAME_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		sb = new();
		plan = new();
		sb.reset_state();
		plan.reset_state();
		fed_items = 0;
		burst_left = 0;
		phases = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 3x3 frame: full-scale pixels with a dark center, a drain while idle,
		// a drain mid-frame and a pixel that lands during the flush
		set_frame(3, 3);
		offer(bmf_pkg::FUNC_DRAIN, 8'hA5);
		for (int i = 0; i < 9; i++) begin
			if (i == 5)
				offer(bmf_pkg::FUNC_DRAIN, 8'h3C);
			offer(bmf_pkg::FUNC_PIXEL, (i == 4) ? 8'd0 : 8'd255);
		end
		offer(bmf_pkg::FUNC_PIXEL, 8'h5A);
		repeat (4) offer(bmf_pkg::FUNC_DRAIN, 8'h00);
		offer(bmf_pkg::FUNC_DRAIN, 8'hFF);
		// single line: the first drain only completes the lag
		set_frame(3, 1);
		offer(bmf_pkg::FUNC_PIXEL, 8'd0);
		offer(bmf_pkg::FUNC_PIXEL, 8'd255);
		offer(bmf_pkg::FUNC_PIXEL, 8'd128);
		repeat (4) offer(bmf_pkg::FUNC_DRAIN, 8'h81);
		close_stream();

		start_count = fed_items;
		while (fed_items - start_count < 1150) begin
			if ($urandom_range(0, 4) == 0) begin
				w = $urandom_range(1, 40);
				h = $urandom_range(1, 6);
			end else begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 6);
			end
			set_frame(w, h);
			repeat ($urandom_range(1, 2)) send_frame(w, h, 1'b1);
			close_stream();
		end

		// zero in both registers acts as a one-pixel frame
		set_frame(0, 0);
		repeat (3) send_frame(1, 1, 1'b1);
		close_stream();

		wait_drained();
		$display("fed %0d effective items over %0d frame settings (widths 0..40, heights 0..6)",
			fed_items, phases);
		$display("checked %0d means, %0d frame ends, %0d mismatches",
			sb.results_seen, sb.frame_ends, sb.mismatches);
		if (sb.mismatches == 0 && sb.owed_means.size() == 0) begin
			$display("box_mean_filter_3x3_top_test passed");
		end else begin
			$display("box_mean_filter_3x3_top_test failed");
		end
		$finish;
	end

endmodule
